>>> hdl/guest_region_translation_table_assert.svh
// Assertion macros for the guest region translation table.
`ifndef GUEST_REGION_TRANSLATION_TABLE_ASSERT_SVH
`define GUEST_REGION_TRANSLATION_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define GRTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grtt assertion failed");
// Next-cycle implication, disabled during reset.
`define GRTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grtt assertion failed");
`else
`define GRTT_ASSERT_IMP(lbl, ante, cons)
`define GRTT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/grtt_pkg.sv
// Shared request codes and default sizes for the guest region translation table.
package grtt_pkg;

  typedef enum logic [2:0] {
    KIND_MAP         = 3'd0,
    KIND_UNMAP       = 3'd1,
    KIND_SPAN        = 3'd2,
    KIND_PROTECT     = 3'd3,
    KIND_UNMAP_RANGE = 3'd4,
    KIND_RESOLVE     = 3'd5,
    KIND_REVERSE     = 3'd6,
    KIND_HOST_IN_USE = 3'd7
  } kind_t;

  localparam int TABLE_ENTRIES_DEF  = 64;
  localparam int HOST_ADDR_BITS_DEF = 48;
  localparam int TAG_BITS_DEF       = 32;

  // One past the last guest byte.
  localparam logic [32:0] GUEST_TOP = 33'h1_0000_0000;

endpackage

>>> hdl/grtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module grtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/guest_region_translation_table.sv
// Guest region translation table: sorted region store with eight request kinds.
//
// The table holds up to TABLE_ENTRIES non-overlapping guest regions sorted by
// guest base, stored in two RAM banks. Every request is one linear pass over
// the stored regions by a small sequencer. Each region goes through a RAM
// read, an evaluate step and a write-back step, with a write-back for each
// record that the region leaves. A map writes its new record either with
// the region it precedes or, past the last region, in a write-back of its
// own, and protect and unmap range write extra records for each split boundary
// region. Requests that change the table (map, unmap, protect, unmap range)
// rewrite every surviving record into the idle bank. On success the banks
// swap; on failure the live bank is left as it was. The input side stalls
// while a request is in work. One finished result may wait in the output
// register while the next request is accepted. Table entries need no
// clearing after reset: only entries below the region count are ever read.

`include "guest_region_translation_table_assert.svh"

module guest_region_translation_table #(
  parameter int TABLE_ENTRIES  = grtt_pkg::TABLE_ENTRIES_DEF,
  parameter int HOST_ADDR_BITS = grtt_pkg::HOST_ADDR_BITS_DEF,
  parameter int TAG_BITS       = grtt_pkg::TAG_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_kind,
  input  logic [31:0]               in_guest_addr,
  input  logic [31:0]               in_length,
  input  logic [HOST_ADDR_BITS-1:0] in_host_addr,
  input  logic [1:0]                in_access,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_ok,
  output logic [31:0]               out_span_length,
  output logic [HOST_ADDR_BITS-1:0] out_host_result,
  output logic [31:0]               out_guest_result
);

  import grtt_pkg::*;

  localparam int HB   = HOST_ADDR_BITS;
  localparam int TB   = TAG_BITS;
  localparam int AW   = $clog2(TABLE_ENTRIES);
  localparam int IDXW = $clog2(TABLE_ENTRIES + 1);
  localparam int NW   = $clog2(TABLE_ENTRIES + 3);

  typedef struct packed {
    logic [31:0]   base;
    logic [31:0]   len;
    logic [HB-1:0] host;
    logic [1:0]    perm;
    logic [TB-1:0] tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_WR,
    ST_DONE
  } state_t;

  state_t          state_r;
  logic [IDXW-1:0] count_r;
  logic [TB-1:0]   next_tag_r;
  logic            bank_r;
  logic [IDXW-1:0] idx_r;
  logic [NW-1:0]   n_r;
  logic            tail_r;

  // Latched request
  kind_t           kind_r;
  logic [31:0]     g_r;
  logic [31:0]     len_r;
  logic [HB-1:0]   h_r;
  logic [1:0]      acc_r;

  // Pass trackers
  logic            ins_r;
  logic            hit_r;
  logic [1:0]      hits_r;
  logic            fail_r;
  logic            started_r;
  logic [32:0]     cur_r;
  logic [TB-1:0]   tag0_r;
  logic [HB-1:0]   start_r;
  logic [31:0]     span_r;
  logic [HB-1:0]   hres_r;
  logic [31:0]     gres_r;

  // Pending records of one region
  rec_t            slot_r [3];
  logic [2:0]      slot_v_r;

  // Result register
  logic            out_valid_r;
  logic            out_ok_r;
  logic [31:0]     out_span_r;
  logic [HB-1:0]   out_host_r;
  logic [31:0]     out_guest_r;

  // RAM ports
  logic [REC_W-1:0] rdata_a;
  logic [REC_W-1:0] rdata_b;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  rec_t             ram_wdata;
  logic [AW-1:0]    ram_raddr;

  grtt_ram #(.WIDTH(REC_W), .DEPTH(TABLE_ENTRIES)) u_bank_a (
    .clk   (clk),
    .we    (ram_we && bank_r),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata_a)
  );

  grtt_ram #(.WIDTH(REC_W), .DEPTH(TABLE_ENTRIES)) u_bank_b (
    .clk   (clk),
    .we    (ram_we && !bank_r),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata_b)
  );

  // Request-wide checks
  logic [32:0] end_w;
  logic [HB:0] host_sum;
  logic        len_zero;
  logic        host_zero;
  logic        guest_bad;
  logic        host_bad;
  logic        host_pre;

  assign end_w     = {1'b0, g_r} + {1'b0, len_r};
  assign host_sum  = {1'b0, h_r} + (HB+1)'(len_r) - (HB+1)'(1);
  assign len_zero  = (len_r == '0);
  assign host_zero = (h_r == '0);
  assign guest_bad = (end_w > GUEST_TOP);
  // The host range runs past the top of the address space when the last byte carries out.
  assign host_bad  = host_sum[HB];
  assign host_pre  = !host_zero && !len_zero && !host_bad;

  // Region evaluation, on the record just read from the live bank
  rec_t          rd_rec;
  logic [32:0]   r_end;
  logic [31:0]   g_off;
  logic          r_le_g;
  logic          r_holds_g;
  logic          r_untouched;
  logic          perm_ok;
  logic          overlap;
  logic [31:0]   first;
  logic [32:0]   clip_end;
  logic [32:0]   m_len_w;
  logic [32:0]   s_len_w;
  logic [32:0]   s_off_w;
  logic [HB:0]   s_host_w;
  logic [HB-1:0] m_host;
  logic [HB-1:0] h_off;
  logic          rev_hit;
  logic          hiu_hit;
  logic [32:0]   cur_off_w;
  logic [HB-1:0] res_expect;
  logic [31:0]   avail;
  rec_t          new_rec;
  rec_t          p_rec;
  rec_t          m_rec;
  rec_t          s_rec;

  always_comb begin
    rd_rec      = bank_r ? rec_t'(rdata_b) : rec_t'(rdata_a);
    r_end       = {1'b0, rd_rec.base} + {1'b0, rd_rec.len};
    g_off       = g_r - rd_rec.base;
    r_le_g      = (rd_rec.base <= g_r);
    r_holds_g   = r_le_g && (g_off < rd_rec.len);
    r_untouched = (r_end <= {1'b0, g_r}) || ({1'b0, rd_rec.base} >= end_w);
    perm_ok     = ((rd_rec.perm & acc_r) == acc_r);
    overlap     = r_le_g ? (g_off < rd_rec.len) : ((rd_rec.base - g_r) < len_r);
    first       = (rd_rec.base < g_r) ? g_r : rd_rec.base;
    clip_end    = (r_end < end_w) ? r_end : end_w;
    m_len_w     = clip_end - {1'b0, first};
    s_len_w     = r_end - end_w;
    s_off_w     = end_w - {1'b0, rd_rec.base};
    s_host_w    = {1'b0, rd_rec.host} + (HB+1)'(s_off_w);
    m_host      = rd_rec.host + HB'(first - rd_rec.base);
    h_off       = h_r - rd_rec.host;
    rev_hit     = (h_r >= rd_rec.host) && (h_off < HB'(rd_rec.len)) &&
                  (len_r <= rd_rec.len - h_off[31:0]);
    hiu_hit     = (rd_rec.host >= h_r) ? ((rd_rec.host - h_r) < HB'(len_r))
                                       : ((h_r - rd_rec.host) < HB'(rd_rec.len));
    cur_off_w   = cur_r - {1'b0, g_r};
    res_expect  = start_r + HB'(cur_off_w[31:0]);
    avail       = rd_rec.len - g_off;

    new_rec.base = g_r;
    new_rec.len  = len_r;
    new_rec.host = h_r;
    new_rec.perm = acc_r;
    new_rec.tag  = next_tag_r + TB'(1);

    p_rec      = rd_rec;
    p_rec.len  = g_r - rd_rec.base;
    m_rec      = rd_rec;
    m_rec.base = first;
    m_rec.host = m_host;
    m_rec.len  = m_len_w[31:0];
    m_rec.perm = acc_r;
    s_rec      = rd_rec;
    s_rec.base = end_w[31:0];
    s_rec.host = s_host_w[HB-1:0];
    s_rec.len  = s_len_w[31:0];
  end

  // Write port: drain the lowest pending record into the idle bank
  logic [1:0] slot_sel;
  logic [2:0] slot_left;

  always_comb begin
    if (slot_v_r[0]) begin
      slot_sel = 2'd0;
    end else if (slot_v_r[1]) begin
      slot_sel = 2'd1;
    end else begin
      slot_sel = 2'd2;
    end
    slot_left = slot_v_r & ~(3'b001 << slot_sel);
  end

  assign ram_we    = (state_r == ST_WR) && (n_r < NW'(TABLE_ENTRIES));
  assign ram_waddr = n_r[AW-1:0];
  assign ram_wdata = slot_r[slot_sel];
  assign ram_raddr = idx_r[AW-1:0];

  // Final verdict
  logic fin_ok;
  logic fin_mod;
  logic out_free;

  always_comb begin
    case (kind_r)
      KIND_MAP: begin
        fin_ok = host_pre && !guest_bad && !(&next_tag_r) && !hit_r &&
                 (count_r < IDXW'(TABLE_ENTRIES));
      end
      KIND_UNMAP:       fin_ok = hit_r;
      KIND_SPAN:        fin_ok = !len_zero && hit_r;
      KIND_PROTECT: begin
        fin_ok = !len_zero && !guest_bad && !fail_r && (cur_r >= end_w) &&
                 (n_r <= NW'(TABLE_ENTRIES));
      end
      KIND_UNMAP_RANGE: fin_ok = !len_zero && !guest_bad && (n_r <= NW'(TABLE_ENTRIES));
      KIND_RESOLVE: begin
        fin_ok = !len_zero && !guest_bad && started_r && !fail_r && (cur_r == end_w);
      end
      KIND_REVERSE:     fin_ok = host_pre && (hits_r == 2'd1);
      default:          fin_ok = host_pre && hit_r;
    endcase
    case (kind_r)
      KIND_MAP, KIND_UNMAP, KIND_PROTECT, KIND_UNMAP_RANGE: fin_mod = fin_ok;
      default:                                            fin_mod = 1'b0;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      next_tag_r  <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      slot_v_r    <= '0;
    end else begin
      // Retire the waiting result once taken, unless a new one replaces it.
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r    <= kind_t'(in_kind);
            g_r       <= in_guest_addr;
            len_r     <= in_length;
            h_r       <= in_host_addr;
            acc_r     <= in_access;
            idx_r     <= '0;
            n_r       <= '0;
            tail_r    <= 1'b0;
            ins_r     <= 1'b0;
            hit_r     <= 1'b0;
            hits_r    <= '0;
            fail_r    <= 1'b0;
            started_r <= 1'b0;
            cur_r     <= {1'b0, in_guest_addr};
            span_r    <= '0;
            hres_r    <= '0;
            gres_r    <= '0;
            state_r   <= ST_RD;
          end
        end
        ST_RD: begin
          if (idx_r == count_r) begin
            // Past the last region: a map that found no later base appends here.
            if (kind_r == KIND_MAP && !ins_r) begin
              slot_r[0] <= new_rec;
              slot_v_r  <= 3'b001;
              tail_r    <= 1'b1;
              state_r   <= ST_WR;
            end else begin
              state_r <= ST_DONE;
            end
          end else begin
            state_r <= ST_EX;
          end
        end
        ST_EX: begin
          slot_r[0] <= (kind_r == KIND_MAP) ? new_rec : p_rec;
          slot_r[1] <= (kind_r == KIND_PROTECT && !r_untouched) ? m_rec : rd_rec;
          slot_r[2] <= s_rec;
          case (kind_r)
            KIND_MAP: begin
              if (overlap) begin
                hit_r <= 1'b1;
              end
              if (!ins_r && rd_rec.base > g_r) begin
                ins_r    <= 1'b1;
                slot_v_r <= 3'b011;
              end else begin
                slot_v_r <= 3'b010;
              end
            end
            KIND_UNMAP: begin
              if (rd_rec.base == g_r && rd_rec.len == len_r) begin
                hit_r    <= 1'b1;
                slot_v_r <= 3'b000;
              end else begin
                slot_v_r <= 3'b010;
              end
            end
            KIND_SPAN: begin
              slot_v_r <= 3'b000;
              if (r_holds_g && perm_ok) begin
                hit_r  <= 1'b1;
                span_r <= (avail < len_r) ? avail : len_r;
                hres_r <= rd_rec.host + HB'(g_off);
              end
            end
            KIND_PROTECT, KIND_UNMAP_RANGE: begin
              if (r_untouched) begin
                slot_v_r <= 3'b010;
              end else begin
                // Split off the head and tail; protect keeps the middle with new access.
                slot_v_r <= {r_end > end_w, kind_r == KIND_PROTECT, rd_rec.base < g_r};
                if ({1'b0, rd_rec.base} > cur_r) begin
                  fail_r <= 1'b1;
                end
                cur_r <= r_end;
              end
            end
            KIND_RESOLVE: begin
              slot_v_r <= 3'b000;
              if (!started_r) begin
                if (r_holds_g) begin
                  started_r <= 1'b1;
                  tag0_r    <= rd_rec.tag;
                  start_r   <= rd_rec.host + HB'(g_off);
                  cur_r     <= clip_end;
                  if (!perm_ok) begin
                    fail_r <= 1'b1;
                  end
                end
              end else if (cur_r < end_w) begin
                // Follow-on region must start where the last ended, same tag, same host run.
                if (({1'b0, rd_rec.base} != cur_r) || (rd_rec.tag != tag0_r) || !perm_ok ||
                    (rd_rec.host != res_expect)) begin
                  fail_r <= 1'b1;
                end
                cur_r <= clip_end;
              end
            end
            KIND_REVERSE: begin
              slot_v_r <= 3'b000;
              if (rev_hit) begin
                hits_r <= (hits_r == 2'd0) ? 2'd1 : 2'd2;
                gres_r <= rd_rec.base + h_off[31:0];
              end
            end
            default: begin
              slot_v_r <= 3'b000;
              if (hiu_hit) begin
                hit_r <= 1'b1;
              end
            end
          endcase
          state_r <= ST_WR;
        end
        ST_WR: begin
          if (slot_v_r != 3'b000) begin
            n_r      <= n_r + NW'(1);
            slot_v_r <= slot_left;
          end
          if (slot_left == 3'b000 || slot_v_r == 3'b000) begin
            if (tail_r) begin
              state_r <= ST_DONE;
            end else begin
              idx_r   <= idx_r + IDXW'(1);
              state_r <= ST_RD;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= fin_ok;
            out_span_r  <= (fin_ok && kind_r == KIND_SPAN) ? span_r : '0;
            out_host_r  <= !fin_ok ? '0 :
                           (kind_r == KIND_SPAN) ? hres_r :
                           (kind_r == KIND_RESOLVE) ? start_r : '0;
            out_guest_r <= (fin_ok && kind_r == KIND_REVERSE) ? gres_r : '0;
            // Swap in the rewritten bank only on success.
            if (fin_mod) begin
              bank_r  <= !bank_r;
              count_r <= IDXW'(n_r);
            end
            if (fin_mod && kind_r == KIND_MAP) begin
              next_tag_r <= next_tag_r + TB'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_span_length  = out_span_r;
  assign out_host_result  = out_host_r;
  assign out_guest_result = out_guest_r;

  `GRTT_ASSERT_IMP(a_count_bound, 1'b1, count_r <= IDXW'(TABLE_ENTRIES))
  `GRTT_ASSERT_IMP(a_fail_clean, out_valid_r && !out_ok_r, out_span_r == '0 && out_host_r == '0 && out_guest_r == '0)
  `GRTT_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, state_r == ST_RD)
  `GRTT_ASSERT_NXT(a_bank_hold, state_r != ST_DONE, bank_r == $past(bank_r))

endmodule
